// ===== hw/rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed list store package
// Shared constants, command and status codes, and the controller/datapath
// interface structs.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned IlsCapacity  = 64;
  localparam int unsigned IlsDataWidth = 32;

  localparam int unsigned CmdWidth    = 2;
  localparam int unsigned PosWidth    = 7;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 7;

  typedef enum logic [CmdWidth-1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the incoming transaction
    logic rd_en;      // issue a store read
    logic cap_rd;     // capture read data as the read result
    logic wr_shift;   // write the read data back one place over
    logic wr_val;     // write the new value at the position
    logic idx_dec;
    logic idx_inc;
    logic out_load;   // load the result register and update the count
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CmdWidth-1:0] cmd;
    logic                err_range;
    logic                err_full;
    logic                no_shift;
    logic                loop_last;
    logic                out_busy;
  } dp_status_t;

endpackage

// ===== hw/rtl/ils_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== hw/rtl/ils_ctrl.sv =====
// ----------------------------------------------------------------------------
// Indexed list store controller
// Sequences reads, shift loops and result hand-off for one command at a time.
// ----------------------------------------------------------------------------
module ils_ctrl
  import ils_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECIDE  = 4'd1;
  localparam logic [3:0] S_RD_WAIT = 4'd2;
  localparam logic [3:0] S_INS_RD  = 4'd3;
  localparam logic [3:0] S_INS_WR  = 4'd4;
  localparam logic [3:0] S_INS_VAL = 4'd5;
  localparam logic [3:0] S_RM_RD   = 4'd6;
  localparam logic [3:0] S_RM_WR   = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status_i.err_range || status_i.err_full) begin
          state_d = S_DONE;
        end else begin
          case (status_i.cmd)
            CMD_READ: begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_RD_WAIT;
            end
            CMD_INSERT: begin
              if (status_i.no_shift) begin
                state_d = S_INS_VAL;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d     = S_INS_WR;
              end
            end
            CMD_REMOVE: begin
              if (status_i.no_shift) begin
                state_d = S_DONE;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d     = S_RM_WR;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd_o.cap_rd = 1'b1;
        state_d      = S_DONE;
      end
      S_INS_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_INS_WR;
      end
      S_INS_WR: begin
        cmd_o.wr_shift = 1'b1;
        if (status_i.loop_last) begin
          state_d = S_INS_VAL;
        end else begin
          cmd_o.idx_dec = 1'b1;
          state_d       = S_INS_RD;
        end
      end
      S_INS_VAL: begin
        cmd_o.wr_val = 1'b1;
        state_d      = S_DONE;
      end
      S_RM_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RM_WR;
      end
      S_RM_WR: begin
        cmd_o.wr_shift = 1'b1;
        if (status_i.loop_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RM_RD;
        end
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/ils_datapath.sv =====
// ----------------------------------------------------------------------------
// Indexed list store datapath
// Holds the entry store, the count, the loop index and the result register.
// ----------------------------------------------------------------------------
module ils_datapath
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY   = IlsCapacity,
  parameter int unsigned DATA_WIDTH = IlsDataWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [CmdWidth-1:0]           command_i,
  input  logic [PosWidth-1:0]           position_i,
  input  logic signed [ValueWidth-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ValueWidth-1:0]  read_value_o,
  output logic [StatusWidth-1:0]        status_o,
  output logic [CountWidth-1:0]         entry_count_o,
  input  ctrl_cmd_t                     cmd_i,
  output dp_status_t                    dp_status_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW    = (CNT_W > PosWidth) ? CNT_W : PosWidth;

  logic [CmdWidth-1:0]   cmd_q;
  logic [CW-1:0]         pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [AW-1:0]         idx_q;
  logic [ValueWidth-1:0] rdval_q;

  logic                          out_valid_q;
  logic [ValueWidth-1:0]         out_value_q;
  logic [StatusWidth-1:0]        out_status_q;
  logic [CountWidth-1:0]         out_count_q;

  logic signed [63:0]            val_ext;
  logic signed [DATA_WIDTH-1:0]  rd_s;
  logic signed [63:0]            rd_ext;
  logic [CW-1:0]                 cnt_w;
  logic [CW-1:0]                 idx_w;
  logic                          err_range;
  logic                          err_full;
  status_e                       status_code;

  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  logic [DATA_WIDTH-1:0] ram_wr_data;
  logic [AW-1:0]         ram_rd_addr;
  logic [DATA_WIDTH-1:0] ram_rd_data;

  assign val_ext = 64'(value_i);
  assign rd_s    = ram_rd_data;
  assign rd_ext  = 64'(rd_s);
  assign cnt_w   = CW'(count_q);
  assign idx_w   = CW'(idx_q);

  // Range and capacity checks against the count before this command.
  always_comb begin
    err_range = 1'b0;
    err_full  = 1'b0;
    case (cmd_q)
      CMD_READ:   err_range = (pos_q >= cnt_w);
      CMD_INSERT: begin
        err_range = (pos_q > cnt_w);
        err_full  = (count_q == CNT_W'(CAPACITY));
      end
      CMD_REMOVE: err_range = (pos_q >= cnt_w);
      default: begin
        err_range = 1'b0;
      end
    endcase
    if (err_range) begin
      status_code = ST_RANGE;
    end else if (err_full) begin
      status_code = ST_FULL;
    end else begin
      status_code = ST_DONE;
    end
  end

  always_comb begin
    dp_status_o.cmd       = cmd_q;
    dp_status_o.err_range = err_range;
    dp_status_o.err_full  = err_full;
    dp_status_o.out_busy  = out_valid_q && out_stall_i;
    if (cmd_q == CMD_REMOVE) begin
      dp_status_o.no_shift  = ((CW+1)'(pos_q) + (CW+1)'(1)) >= (CW+1)'(cnt_w);
      dp_status_o.loop_last = ((CW+1)'(idx_w) + (CW+1)'(2)) >= (CW+1)'(cnt_w);
    end else begin
      dp_status_o.no_shift  = (pos_q == cnt_w);
      dp_status_o.loop_last = (idx_w == pos_q);
    end
  end

  // Store addressing: insert moves entries toward the tail, remove toward
  // the head.
  always_comb begin
    ram_rd_addr = (cmd_q == CMD_REMOVE) ? AW'(idx_q + 1'b1) : idx_q;
    ram_wr_en   = cmd_i.wr_shift || cmd_i.wr_val;
    ram_wr_data = cmd_i.wr_val ? val_q : ram_rd_data;
    if (cmd_i.wr_val) begin
      ram_wr_addr = AW'(pos_q);
    end else if (cmd_q == CMD_INSERT) begin
      ram_wr_addr = AW'(idx_q + 1'b1);
    end else begin
      ram_wr_addr = idx_q;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.out_load && (status_code == ST_DONE)) begin
      if (cmd_q == CMD_INSERT) begin
        count_d = count_q + 1'b1;
      end else if (cmd_q == CMD_REMOVE) begin
        count_d = count_q - 1'b1;
      end
    end
  end

  ils_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk_i    (clk_i),
    .wr_en_i  (ram_wr_en),
    .wr_addr_i(ram_wr_addr),
    .wr_data_i(ram_wr_data),
    .rd_en_i  (cmd_i.rd_en),
    .rd_addr_i(ram_rd_addr),
    .rd_data_o(ram_rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= command_i;
      pos_q   <= CW'(position_i);
      val_q   <= val_ext[DATA_WIDTH-1:0];
      rdval_q <= '1;
      if (command_i == CMD_INSERT) begin
        idx_q <= AW'(count_q - 1'b1);
      end else begin
        idx_q <= AW'(position_i);
      end
    end else begin
      if (cmd_i.idx_dec) begin
        idx_q <= idx_q - 1'b1;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.cap_rd) begin
        rdval_q <= rd_ext[ValueWidth-1:0];
      end
    end
    if (cmd_i.out_load) begin
      out_value_q  <= rdval_q;
      out_status_q <= status_code;
      out_count_q  <= CountWidth'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_value_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;

endmodule

// ===== hw/rtl/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// Indexed list store
// Ordered list of up to CAPACITY signed values with read, insert and remove
// by position, one command at a time.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one command per transaction (read, insert
// or remove at a position, with a value for insert). Every accepted command
// answers with exactly one transaction on the output channel: the read value
// (all ones unless a good read), a status (done, out of range, list full) and
// the entry count after the command.
// The accepted command is first checked for range and capacity. A read issues
// a store read and captures the data. An insert shifts the entries from the
// tail down to the position one place toward the tail, a read and a write
// each, then writes the value (no shift on an append). A remove shifts the
// entries after the position toward the head. Refused commands go straight to
// the result. The shift loop moves entries one at a time through the single
// read and single write port of the entry RAM, so that loop sets the rate.
// The input stalls while a command is in progress and is open again as soon
// as its result sits in the output register, so a new command can start while
// the previous result waits. If the receiver stalls, the finished command
// holds in its last step until the output register frees up.
// Reset clears the count and the output valid; the entry RAM is not cleared
// and needs no clearing pass, since only positions below the count are read.
// ----------------------------------------------------------------------------
module indexed_list_store
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY   = IlsCapacity,
  parameter int unsigned DATA_WIDTH = IlsDataWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [CmdWidth-1:0]           command_i,
  input  logic [PosWidth-1:0]           position_i,
  input  logic signed [ValueWidth-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ValueWidth-1:0]  read_value_o,
  output logic [StatusWidth-1:0]        status_o,
  output logic [CountWidth-1:0]         entry_count_o
);

  // Command and status bundles between the sequencer and the datapath.
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  ils_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (dp_status),
    .cmd_o     (ctrl_cmd)
  );

  ils_datapath #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (command_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .cmd_i        (ctrl_cmd),
    .dp_status_o  (dp_status)
  );

endmodule

// ===== tb/sv/indexed_list_store_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store testbench
// Drives read, insert and remove commands into the list store and checks
// every result against a shadow copy of the list kept in the testbench. A
// short directed opening covers the edge cases. Random traffic follows that
// fills the list to capacity, runs it into the full state and drains it
// again, with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module indexed_list_store_test;
  import ils_pkg::*;

  localparam logic [CmdWidth-1:0]          CmdUnused   = 2'd3;
  localparam logic signed [ValueWidth-1:0] NoReadValue = -1;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned DrainAtItem = 300;   // random item that waits for an empty pipe
  localparam int unsigned HoldAt      = 200;   // accepted commands before the output hold
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned CalmFrom    = 450;   // window of accepted commands with no idling
  localparam int unsigned CalmTo      = 550;

  typedef struct {
    logic [CmdWidth-1:0]          cmd;
    logic [PosWidth-1:0]          pos;
    logic signed [ValueWidth-1:0] value;
    bit                           drain;
  } list_cmd_t;

  typedef struct {
    logic signed [ValueWidth-1:0] read_value;
    logic [StatusWidth-1:0]       status;
    logic [CountWidth-1:0]        count;
  } list_result_t;

  typedef enum int {
    MODE_GROW,
    MODE_SHRINK,
    MODE_MIX
  } traffic_mode_e;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic [CmdWidth-1:0]          command_i     = '0;
  logic [PosWidth-1:0]          position_i    = '0;
  logic signed [ValueWidth-1:0] value_i       = '0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic signed [ValueWidth-1:0] read_value_o;
  logic [StatusWidth-1:0]       status_o;
  logic [CountWidth-1:0]        entry_count_o;

  indexed_list_store i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .position_i,
    .value_i,
    .out_valid_o,
    .out_stall_i,
    .read_value_o,
    .status_o,
    .entry_count_o
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the list contents and length as the block should hold them.
  logic signed [ValueWidth-1:0] shadow_entries [IlsCapacity];
  int unsigned                  shadow_count = 0;

  list_cmd_t    cmd_backlog [$];
  list_result_t expected_results [$];
  int unsigned  gen_count     = 0;   // list length as the generator foresees it
  int unsigned  accepted_cnt  = 0;
  int unsigned  mismatch_cnt  = 0;
  int unsigned  hold_left     = 0;
  bit           hold_done     = 1'b0;
  bit           in_fire       = 1'b0;
  bit           calm;

  assign calm = (accepted_cnt >= CalmFrom) && (accepted_cnt < CalmTo);

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatch_cnt++;
  endtask

  // Applies one command to the shadow list and returns the result it causes.
  task automatic apply_list_command(input list_cmd_t c, output list_result_t r);
    int unsigned i;
    r.read_value = NoReadValue;
    r.status     = ST_DONE;
    case (c.cmd)
      CMD_READ: begin
        if (c.pos >= shadow_count) r.status = ST_RANGE;
        else r.read_value = shadow_entries[c.pos];
      end
      CMD_INSERT: begin
        if (c.pos > shadow_count) begin
          r.status = ST_RANGE;
        end else if (shadow_count >= IlsCapacity) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > c.pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[c.pos] = c.value;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (c.pos >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          for (i = c.pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.count = shadow_count[CountWidth-1:0];
  endtask

  // Queues a command and tracks the list length it will leave behind.
  task automatic queue_command(input logic [CmdWidth-1:0] cmd, input int unsigned pos,
                               input logic signed [ValueWidth-1:0] value,
                               input bit drain = 1'b0);
    list_cmd_t c;
    c.cmd   = cmd;
    c.pos   = pos[PosWidth-1:0];
    c.value = value;
    c.drain = drain;
    cmd_backlog.push_back(c);
    if (cmd == CMD_INSERT && pos <= gen_count && gen_count < IlsCapacity) gen_count++;
    else if (cmd == CMD_REMOVE && pos < gen_count) gen_count--;
  endtask

  function automatic logic signed [ValueWidth-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return NoReadValue;
      3: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions that hit the list, now and then any position up to the capacity.
  function automatic int unsigned rand_position(input logic [CmdWidth-1:0] cmd);
    if ($urandom_range(99) >= 85) return $urandom_range(IlsCapacity, 0);
    if (cmd == CMD_INSERT) return $urandom_range(gen_count, 0);
    if (gen_count == 0) return 0;
    return $urandom_range(gen_count - 1, 0);
  endfunction

  // Input driver: presents the next queued command once the previous one has
  // been taken. A command marked to drain waits until every result is back.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (cmd_backlog.size() != 0 &&
          !(cmd_backlog[0].drain && expected_results.size() != 0) &&
          (calm || $urandom_range(99) >= 30)) begin
        command_i  <= cmd_backlog[0].cmd;
        position_i <= cmd_backlog[0].pos;
        value_i    <= cmd_backlog[0].value;
        in_valid_i <= 1'b1;
        void'(cmd_backlog.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long output hold-off, started once after enough commands have gone in.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_cnt >= HoldAt) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= (hold_left != 0) || (!calm && $urandom_range(99) < 30);
    end
  end

  // Monitor: checks results and predicts each accepted command.
  always @(posedge clk_i) begin
    list_cmd_t    c;
    list_result_t r;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with no command waiting");
      end else begin
        r = expected_results.pop_front();
        if (read_value_o !== r.read_value)
          report_mismatch($sformatf("read_value %0d, expected %0d", read_value_o,
                                    r.read_value));
        if (status_o !== r.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, r.status));
        if (entry_count_o !== r.count)
          report_mismatch($sformatf("entry_count %0d, expected %0d", entry_count_o,
                                    r.count));
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      c.cmd   = command_i;
      c.pos   = position_i;
      c.value = value_i;
      c.drain = 1'b0;
      apply_list_command(c, r);
      expected_results.push_back(r);
      accepted_cnt <= accepted_cnt + 1;
    end
  end

  initial begin
    traffic_mode_e mode;
    logic [CmdWidth-1:0] cmd;
    int unsigned pick;
    int unsigned full_extra;
    int unsigned mix_left;

    // Directed opening on an empty list: refusals, head, tail and middle
    // inserts, extreme values, reads around the ends and the unused code.
    queue_command(CMD_READ,   0, 0);
    queue_command(CMD_REMOVE, 0, 0);
    queue_command(CMD_INSERT, 1, 5);
    queue_command(CMD_INSERT, 0, 32'sh7FFF_FFFF);
    queue_command(CMD_INSERT, 0, 32'sh8000_0000);
    queue_command(CMD_INSERT, 2, NoReadValue);
    queue_command(CMD_INSERT, 1, 0);
    for (int p = 0; p < 5; p++) queue_command(CMD_READ, p, 0);
    queue_command(CMD_READ,   IlsCapacity, 0);
    queue_command(CMD_INSERT, IlsCapacity, 7);
    queue_command(CMD_REMOVE, IlsCapacity, 0);
    queue_command(CmdUnused,  0, 5);
    queue_command(CmdUnused,  IlsCapacity, NoReadValue);
    queue_command(CMD_REMOVE, 3, 0);
    queue_command(CMD_REMOVE, 0, 0, 1'b1);
    queue_command(CMD_READ,   0, 0);
    queue_command(CMD_READ,   1, 0);
    queue_command(CMD_REMOVE, 1, 0);
    queue_command(CMD_REMOVE, 0, 0);
    queue_command(CMD_READ,   0, 0);

    // Random traffic: fill the list, push on it while full, empty it, mix.
    mode       = MODE_GROW;
    full_extra = 0;
    mix_left   = 0;
    for (int n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(99);
      case (mode)
        MODE_GROW:   cmd = pick < 2 ? CmdUnused : pick < 65 ? CMD_INSERT :
                           pick < 85 ? CMD_READ : CMD_REMOVE;
        MODE_SHRINK: cmd = pick < 2 ? CmdUnused : pick < 60 ? CMD_REMOVE :
                           pick < 85 ? CMD_READ : CMD_INSERT;
        default:     cmd = pick < 2 ? CmdUnused : pick < 35 ? CMD_INSERT :
                           pick < 70 ? CMD_READ : CMD_REMOVE;
      endcase
      queue_command(cmd, rand_position(cmd), rand_value(), n == DrainAtItem);
      case (mode)
        MODE_GROW: begin
          if (gen_count == IlsCapacity) full_extra++;
          if (full_extra >= 10) begin
            full_extra = 0;
            mode       = MODE_SHRINK;
          end
        end
        MODE_SHRINK: begin
          if (gen_count == 0) begin
            mix_left = 60;
            mode     = MODE_MIX;
          end
        end
        default: begin
          mix_left--;
          if (mix_left == 0) mode = MODE_GROW;
        end
      endcase
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    // The longest command is a head insert into a nearly full list.
    repeat (2 * IlsCapacity + 20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("indexed_list_store: match");
    end else begin
      $display("indexed_list_store: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("indexed_list_store: mismatch");
    $finish;
  end

endmodule
